[rtl/olwd_pkg.sv]
package olwd_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int VALUE_W       = 32;
    localparam int OCC_W         = 6;

    typedef enum logic [2:0] {
        OP_APPEND       = 3'd0,
        OP_REMOVE_FRONT = 3'd1,
        OP_REMOVE_BACK  = 3'd2,
        OP_REMOVE_VALUE = 3'd3,
        OP_DUMP         = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TAKE,
        S_SRD,
        S_SCMP,
        S_SHR,
        S_SHW,
        S_DRD,
        S_DEMIT
    } t_state;

    // which logical position the memory address is built from
    typedef enum logic [1:0] {
        IDX_POS,
        IDX_POS_NEXT,
        IDX_LAST,
        IDX_TAIL
    } t_idx_sel;

    typedef enum logic [1:0] {
        EV_ZERO,
        EV_RDATA,
        EV_VALUE
    } t_ev_sel;

    typedef struct packed {
        logic     load_in;
        logic     pos_clr;
        logic     pos_inc;
        logic     rd_en;
        logic     wr_en;
        logic     wr_from_rdata;
        t_idx_sel idx_sel;
        logic     head_inc;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     emit;
        t_status  emit_status;
        t_ev_sel  emit_sel;
        logic     emit_last;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       empty;
        logic       full;
        logic       pos_last;
        logic       match;
        logic       out_free;
    } t_sts;

endpackage

[rtl/olwd_ctrl.sv]
module olwd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  olwd_pkg::t_sts i_sts,
    output olwd_pkg::t_cmd o_cmd
);
    import olwd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.op)
                    OP_REMOVE_FRONT, OP_REMOVE_BACK: begin
                        if (!i_sts.empty) begin
                            n_state = S_TAKE;
                        end else if (i_sts.out_free) begin
                            n_state = S_IDLE;
                        end
                    end
                    OP_REMOVE_VALUE: begin
                        if (!i_sts.empty) begin
                            n_state = S_SCMP;
                        end else if (i_sts.out_free) begin
                            n_state = S_IDLE;
                        end
                    end
                    OP_DUMP: begin
                        if (!i_sts.empty) begin
                            n_state = S_DEMIT;
                        end else if (i_sts.out_free) begin
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        if (i_sts.out_free) begin
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_TAKE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SRD: n_state = S_SCMP;
            S_SCMP: begin
                if (i_sts.match) begin
                    n_state = S_SHR;
                end else if (!i_sts.pos_last) begin
                    n_state = S_SRD;
                end else if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SHR: begin
                if (!i_sts.pos_last) begin
                    n_state = S_SHW;
                end else if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SHW: n_state = S_SHR;
            S_DRD: n_state = S_DEMIT;
            S_DEMIT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.pos_last ? S_IDLE : S_DRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd             = '0;
        o_cmd.idx_sel     = IDX_POS;
        o_cmd.emit_status = ST_DONE;
        o_cmd.emit_sel    = EV_ZERO;
        o_cmd.emit_last   = 1'b1;
        o_ready           = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.load_in = i_valid;
                o_cmd.pos_clr = i_valid;
            end
            S_DECODE: begin
                case (i_sts.op)
                    OP_APPEND: begin
                        if (i_sts.out_free) begin
                            o_cmd.emit = 1'b1;
                            if (i_sts.full) begin
                                o_cmd.emit_status = ST_FULL;
                            end else begin
                                o_cmd.wr_en   = 1'b1;
                                o_cmd.idx_sel = IDX_TAIL;
                                o_cmd.cnt_inc = 1'b1;
                            end
                        end
                    end
                    OP_REMOVE_FRONT, OP_REMOVE_BACK, OP_REMOVE_VALUE, OP_DUMP: begin
                        if (!i_sts.empty) begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.idx_sel = (i_sts.op == OP_REMOVE_BACK) ? IDX_LAST : IDX_POS;
                        end else if (i_sts.out_free) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = ST_EMPTY;
                        end
                    end
                    default: begin
                        o_cmd.emit = i_sts.out_free;
                    end
                endcase
            end
            S_TAKE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EV_RDATA;
                    o_cmd.cnt_dec  = 1'b1;
                    o_cmd.head_inc = (i_sts.op == OP_REMOVE_FRONT);
                end
            end
            S_SRD, S_DRD: begin
                o_cmd.rd_en = 1'b1;
            end
            S_SCMP: begin
                if (!i_sts.match) begin
                    if (!i_sts.pos_last) begin
                        o_cmd.pos_inc = 1'b1;
                    end else if (i_sts.out_free) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = ST_NOT_FOUND;
                    end
                end
            end
            S_SHR: begin
                if (!i_sts.pos_last) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.idx_sel = IDX_POS_NEXT;
                end else if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EV_VALUE;
                    o_cmd.cnt_dec  = 1'b1;
                end
            end
            S_SHW: begin
                // move the entry after the gap one place toward the front
                o_cmd.wr_en         = 1'b1;
                o_cmd.wr_from_rdata = 1'b1;
                o_cmd.pos_inc       = 1'b1;
            end
            S_DEMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = EV_RDATA;
                    o_cmd.emit_last = i_sts.pos_last;
                    o_cmd.pos_inc   = !i_sts.pos_last;
                end
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

[rtl/olwd_dp.sv]
module olwd_dp #(
    parameter int DEPTH = olwd_pkg::DEPTH_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  olwd_pkg::t_cmd                      i_cmd,
    output olwd_pkg::t_sts                      o_sts,
    input  logic [2:0]                          i_operation,
    input  logic signed [olwd_pkg::VALUE_W-1:0] i_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_status,
    output logic signed [olwd_pkg::VALUE_W-1:0] o_entry_value,
    output logic [olwd_pkg::OCC_W-1:0]          o_occupancy,
    output logic                                o_last
);
    import olwd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [VALUE_W-1:0] r_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rdata;

    logic [2:0]                r_op;
    logic signed [VALUE_W-1:0] r_value;
    logic [AW-1:0]             r_head;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic [AW-1:0]             r_pos;

    logic                      r_out_valid;
    logic [1:0]                r_out_status;
    logic signed [VALUE_W-1:0] r_out_value;
    logic [OCC_W-1:0]          r_out_occ;
    logic                      r_out_last;

    logic [AW-1:0]             idx;
    logic [AW:0]               addr_sum;
    logic [AW-1:0]             addr;
    logic [CW-1:0]             count_m1;
    logic                      out_free;

    assign count_m1 = r_count - CW'(1);
    assign out_free = !r_out_valid || i_ready;

    // logical position to physical slot of the ring
    always_comb begin
        case (i_cmd.idx_sel)
            IDX_POS:      idx = r_pos;
            IDX_POS_NEXT: idx = r_pos + AW'(1);
            IDX_LAST:     idx = AW'(count_m1);
            IDX_TAIL:     idx = AW'(r_count);
            default:      idx = r_pos;
        endcase
        addr_sum = {1'b0, r_head} + {1'b0, idx};
        if (addr_sum >= (AW+1)'(DEPTH)) begin
            addr = AW'(addr_sum - (AW+1)'(DEPTH));
        end else begin
            addr = AW'(addr_sum);
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = count_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[addr] <= i_cmd.wr_from_rdata ? r_rdata : r_value;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op    <= i_operation;
            r_value <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_pos   <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.head_inc) begin
                r_head <= (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
            end
            if (i_cmd.pos_clr) begin
                r_pos <= '0;
            end else if (i_cmd.pos_inc) begin
                r_pos <= r_pos + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.emit_status;
            r_out_occ    <= OCC_W'(n_count);
            r_out_last   <= i_cmd.emit_last;
            case (i_cmd.emit_sel)
                EV_RDATA: r_out_value <= r_rdata;
                EV_VALUE: r_out_value <= r_value;
                default:  r_out_value <= '0;
            endcase
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.full     = (r_count == CW'(DEPTH));
    assign o_sts.pos_last = (CW'(r_pos) == count_m1);
    assign o_sts.match    = (r_rdata == r_value);
    assign o_sts.out_free = out_free;

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_value = r_out_value;
    assign o_occupancy   = r_out_occ;
    assign o_last        = r_out_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_count_one_way: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.cnt_inc && i_cmd.cnt_dec))
        else $error("count raised and lowered together");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("pending word overwritten");

    a_head_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.head_inc |=> $stable(r_head))
        else $error("head moved without a front removal");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.rd_en && i_cmd.wr_en))
        else $error("memory read and write in one cycle");

endmodule

[rtl/ordered_list_with_delete_core.sv]
// channel  | handshake          | payload
// ---------+--------------------+-----------------------------------------------
// in       | i_valid / o_ready  | i_operation, i_value
// out      | o_valid / i_ready  | o_status, o_entry_value, o_occupancy, o_last
//
// one single-port ring memory (registered read) holds the list, one slot per cycle.
// append, bad op code, empty-list removal: decode and emit; front/back: read, then emit.
// remove-value: compare in turn; hit: shift the entries behind it forward; miss: NOT_FOUND.
// dump: read and emit entries in turn (EMPTY when empty); each out word waits for i_ready.
// reset clears count, pointers, sequencer state and out valid only; a full out word stalls the sequencer.
module ordered_list_with_delete_core #(
    parameter int DEPTH = olwd_pkg::DEPTH_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [2:0]                          i_operation,
    input  logic signed [olwd_pkg::VALUE_W-1:0] i_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_status,
    output logic signed [olwd_pkg::VALUE_W-1:0] o_entry_value,
    output logic [olwd_pkg::OCC_W-1:0]          o_occupancy,
    output logic                                o_last
);
    import olwd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    olwd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    olwd_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_entry_value (o_entry_value),
        .o_occupancy   (o_occupancy),
        .o_last        (o_last)
    );

endmodule

[tb/testbench.sv]
module testbench;

    import olwd_pkg::*;

    localparam int DEPTH         = DEPTH_DEFAULT;
    localparam int OP_CODE_COUNT = 8;
    localparam int RANDOM_WORDS  = 70;
    localparam int HOLD_CYCLES   = 250;
    localparam int TAIL_CYCLES   = 20;
    localparam int LIMIT_TIME    = 2_000_000;

    typedef struct packed {
        t_status                    status;
        logic signed [VALUE_W-1:0]  entry_value;
        logic [OCC_W-1:0]           occupancy;
        logic                       last;
    } t_list_result;

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_valid       = 1'b0;
    logic                       o_ready;
    logic [2:0]                 i_operation   = '0;
    logic signed [VALUE_W-1:0]  i_value       = '0;
    logic                       o_valid;
    logic                       i_ready       = 1'b0;
    logic [1:0]                 o_status;
    logic signed [VALUE_W-1:0]  o_entry_value;
    logic [OCC_W-1:0]           o_occupancy;
    logic                       o_last;

    // own copy of the list, front at index 0
    logic signed [VALUE_W-1:0]  list_model[$];
    t_list_result               awaited_results[$];

    int  fail_count      = 0;
    int  words_sent      = 0;
    int  results_checked = 0;
    int  peak_occupancy  = 0;
    bit  steady          = 1'b0;
    int  hold_request    = 0;
    int  hold_left       = 0;

    ordered_list_with_delete_core #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_entry_value (o_entry_value),
        .o_occupancy   (o_occupancy),
        .o_last        (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic push_result(input t_status st, input logic signed [VALUE_W-1:0] v,
                               input logic lst);
        t_list_result r;
        r.status      = st;
        r.entry_value = v;
        r.occupancy   = OCC_W'(list_model.size());
        r.last        = lst;
        awaited_results.push_back(r);
    endtask

    task automatic apply_list_op(input logic [2:0] op, input logic signed [VALUE_W-1:0] v);
        logic signed [VALUE_W-1:0] got;
        int                        hit;
        case (op)
            OP_APPEND: begin
                if (list_model.size() >= DEPTH) begin
                    push_result(ST_FULL, '0, 1'b1);
                end else begin
                    list_model.push_back(v);
                    push_result(ST_DONE, '0, 1'b1);
                end
            end
            OP_REMOVE_FRONT: begin
                if (list_model.size() == 0) begin
                    push_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    got = list_model.pop_front();
                    push_result(ST_DONE, got, 1'b1);
                end
            end
            OP_REMOVE_BACK: begin
                if (list_model.size() == 0) begin
                    push_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    got = list_model.pop_back();
                    push_result(ST_DONE, got, 1'b1);
                end
            end
            OP_REMOVE_VALUE: begin
                if (list_model.size() == 0) begin
                    push_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    hit = -1;
                    for (int i = 0; i < list_model.size(); i++) begin
                        if (hit < 0 && list_model[i] == v)
                            hit = i;
                    end
                    if (hit < 0) begin
                        push_result(ST_NOT_FOUND, '0, 1'b1);
                    end else begin
                        got = list_model[hit];
                        list_model.delete(hit);
                        push_result(ST_DONE, got, 1'b1);
                    end
                end
            end
            OP_DUMP: begin
                if (list_model.size() == 0) begin
                    push_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < list_model.size(); i++)
                        push_result(ST_DONE, list_model[i], i == list_model.size() - 1);
                end
            end
            default: begin
                push_result(ST_DONE, '0, 1'b1);
            end
        endcase
        if (list_model.size() > peak_occupancy)
            peak_occupancy = list_model.size();
    endtask

    // mix of small values (many duplicates), full-range values and the extremes
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(9);
        if (r < 4)
            return VALUE_W'($signed($urandom_range(6)) - 3);
        else if (r < 8)
            return $urandom;
        else if (r == 8)
            return {1'b1, {(VALUE_W-1){1'b0}}};
        else
            return {1'b0, {(VALUE_W-1){1'b1}}};
    endfunction

    task automatic send_word(input logic [2:0] op, input logic signed [VALUE_W-1:0] v);
        while (!steady && $urandom_range(99) < 13) begin
            i_valid     <= 1'b0;
            i_operation <= 3'($urandom);
            i_value     <= $urandom;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_value     <= v;
        do @(posedge i_clk); while (!o_ready);
        apply_list_op(op, v);
        words_sent++;
    endtask

    // sender goes quiet until every awaited result is back
    task automatic wait_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= steady || ($urandom_range(99) >= 13);
        end
    end

    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result word with nothing awaited: status %0d value %0d",
                       o_status, o_entry_value);
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                results_checked++;
                if (o_status !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_entry_value !== want.entry_value) begin
                    $error("entry_value mismatch: expected %0d, got %0d",
                           want.entry_value, o_entry_value);
                    fail_count++;
                end
                if (o_occupancy !== want.occupancy) begin
                    $error("occupancy mismatch: expected %0d, got %0d",
                           want.occupancy, o_occupancy);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last mismatch: expected %0d, got %0d", want.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_empty_list();
        send_word(OP_REMOVE_FRONT, '0);
        send_word(OP_REMOVE_BACK, '0);
        send_word(OP_REMOVE_VALUE, -32'sd1);
        send_word(OP_DUMP, '0);
    endtask

    task automatic test_value_extremes();
        logic signed [VALUE_W-1:0] vmin;
        logic signed [VALUE_W-1:0] vmax;
        vmin = {1'b1, {(VALUE_W-1){1'b0}}};
        vmax = {1'b0, {(VALUE_W-1){1'b1}}};
        send_word(OP_APPEND, vmin);
        send_word(OP_APPEND, vmax);
        send_word(OP_APPEND, -32'sd1);
        send_word(OP_APPEND, '0);
        send_word(OP_APPEND, vmin);
        send_word(OP_DUMP, '0);
        // match in the middle, then a miss
        send_word(OP_REMOVE_VALUE, vmax);
        send_word(OP_REMOVE_VALUE, 32'sd5);
        send_word(OP_REMOVE_FRONT, '0);
        send_word(OP_REMOVE_BACK, '0);
        send_word(OP_REMOVE_VALUE, -32'sd1);
        send_word(OP_REMOVE_VALUE, '0);
    endtask

    task automatic test_single_entry_back();
        send_word(OP_APPEND, 32'sh0bad_cafe);
        send_word(OP_REMOVE_BACK, '0);
        send_word(OP_DUMP, '0);
    endtask

    task automatic test_unused_codes();
        for (int code = int'(OP_DUMP) + 1; code < OP_CODE_COUNT; code++)
            send_word(3'(code), pick_value());
    endtask

    // receiver holds off while the list is filled, so the block backs up
    task automatic test_fill_under_backpressure();
        hold_request = HOLD_CYCLES;
        while (list_model.size() < DEPTH)
            send_word(OP_APPEND, pick_value());
        send_word(OP_APPEND, 32'sd99);
        send_word(OP_DUMP, '0);
        send_word(OP_REMOVE_VALUE, list_model[DEPTH-1]);
        send_word(OP_REMOVE_VALUE, 32'sh1234_5678);
        send_word(OP_APPEND, pick_value());
        send_word(OP_REMOVE_VALUE, list_model[DEPTH/2]);
        send_word(OP_REMOVE_BACK, '0);
        send_word(OP_REMOVE_FRONT, '0);
        send_word(OP_DUMP, '0);
        wait_drain();
    endtask

    task automatic test_random_mix();
        int                        r;
        int                        grow_pct;
        logic [2:0]                op;
        logic signed [VALUE_W-1:0] v;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            steady   = (n >= 25 && n < 55);
            grow_pct = ((n / 15) % 2 == 0) ? 55 : 20;
            r        = $urandom_range(99);
            v        = pick_value();
            if (r < grow_pct)
                op = OP_APPEND;
            else if (r < grow_pct + 12)
                op = OP_REMOVE_FRONT;
            else if (r < grow_pct + 22)
                op = OP_REMOVE_BACK;
            else if (r < grow_pct + 38)
                op = OP_REMOVE_VALUE;
            else if (r < 96)
                op = OP_DUMP;
            else
                op = 3'($urandom_range(OP_CODE_COUNT - 1, int'(OP_DUMP) + 1));
            // mostly search for something that is really there
            if (op == OP_REMOVE_VALUE && list_model.size() != 0 && $urandom_range(9) < 7)
                v = list_model[$urandom_range(list_model.size() - 1)];
            send_word(op, v);
            if (n == 60)
                wait_drain();
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_list();
        test_value_extremes();
        test_single_entry_back();
        test_unused_codes();
        test_fill_under_backpressure();
        test_random_mix();
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d words in, %0d result words checked, peak occupancy %0d of %0d",
                 words_sent, results_checked, peak_occupancy, DEPTH);
        $display("all ops incl. unused codes, empty/full/not-found cases, long output stall");
        if (fail_count == 0 && awaited_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(LIMIT_TIME);
        $display("timeout with %0d result words still awaited", awaited_results.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
rtl/olwd_pkg.sv
rtl/olwd_ctrl.sv
rtl/olwd_dp.sv
rtl/ordered_list_with_delete_core.sv
tb/testbench.sv
